>>> rtl/ihex_pkg.sv
// ----------------------------------------------------------------------------
// ihex_pkg: shared types and constants
// Character tokens, result items and code values of the hex record parser.
// ----------------------------------------------------------------------------
package ihex_pkg;

    // Segments at or above this base are skipped.
    localparam logic [31:0] IMAGE_LIMIT = 32'd131072;
    localparam int          ADDR_W      = 18;
    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam logic [7:0] REC_DATA  = 8'h00;
    localparam logic [7:0] REC_EOF   = 8'h01;
    localparam logic [7:0] REC_START = 8'h03;
    localparam logic [7:0] REC_ELA   = 8'h04;

    localparam logic [1:0] ST_BUSY   = 2'd0;
    localparam logic [1:0] ST_ACCEPT = 2'd1;
    localparam logic [1:0] ST_ERROR  = 2'd2;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_COLON    = 3'd1;
    localparam logic [2:0] ERR_HEX      = 3'd2;
    localparam logic [2:0] ERR_TYPE     = 3'd3;
    localparam logic [2:0] ERR_CHECKSUM = 3'd4;

    typedef struct packed {
        logic       is_colon;
        logic       is_newline;
        logic       is_hex;
        logic [3:0] nibble;
    } t_token;

    typedef struct packed {
        logic              write_valid;
        logic [ADDR_W-1:0] write_addr;
        logic [7:0]        write_data;
        logic [1:0]        status;
        logic [2:0]        error_code;
        logic [ADDR_W-1:0] image_end;
    } t_result;

    function automatic t_token classify(input logic [7:0] ch);
        t_token t;
        t.is_colon   = (ch == CH_COLON);
        t.is_newline = (ch == CH_NEWLINE);
        t.is_hex     = 1'b1;
        t.nibble     = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            t.nibble = 4'(ch - 8'h30);
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            t.nibble = 4'(ch - 8'h37);
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            t.nibble = 4'(ch - 8'h57);
        end else begin
            t.is_hex = 1'b0;
        end
        return t;
    endfunction

endpackage

>>> rtl/ihex_front.sv
// ----------------------------------------------------------------------------
// ihex_front: character intake
// Classifies each character and holds the tokens in a two-entry queue.
// ----------------------------------------------------------------------------
module ihex_front import ihex_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_ch,
    output logic       o_tok_valid,
    output t_token     o_tok,
    input  logic       i_tok_pop
);

    t_token     r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign full        = (r_cnt == 2'd2);
    assign o_tok_valid = (r_cnt != 2'd0);
    assign o_tok       = r_mem[r_rd];
    assign do_push     = push && !full;
    assign do_pop      = i_tok_pop && o_tok_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= classify(i_ch);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

>>> rtl/ihex_back.sv
// ----------------------------------------------------------------------------
// ihex_back: record decoder
// Walks the record fields, emits writes and status, and queues results.
// ----------------------------------------------------------------------------
module ihex_back import ihex_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_tok_valid,
    input  t_token  i_tok,
    output logic    o_tok_pop,
    output logic    o_res_empty,
    output t_result o_res,
    input  logic    i_res_pop
);

    typedef enum logic [3:0] {
        PH_COLON, PH_LEN, PH_AHI, PH_ALO, PH_TYPE,
        PH_DATA, PH_ELAHI, PH_ELALO, PH_CHECK, PH_SKIP
    } t_phase;

    t_phase            r_phase,  n_phase;
    logic              r_low,    n_low;
    logic [3:0]        r_hi,     n_hi;
    logic [7:0]        r_len,    n_len;
    logic [15:0]       r_addr,   n_addr;
    logic [7:0]        r_cnt,    n_cnt;
    logic [7:0]        r_sum,    n_sum;
    logic [15:0]       r_seg,    n_seg;
    logic [ADDR_W-1:0] r_top,    n_top;
    logic [2:0]        r_err,    n_err;

    t_result     r_rq [2];
    logic        r_rq_wr;
    logic        r_rq_rd;
    logic [1:0]  r_rq_cnt;

    t_result     res;
    logic        commit;
    logic        do_pop;
    logic [7:0]  b;
    logic        seg_over;
    logic [32:0] wr_addr;
    logic [32:0] wr_end;

    assign commit      = i_tok_valid && (r_rq_cnt != 2'd2);
    assign o_tok_pop   = commit;
    assign o_res_empty = (r_rq_cnt == 2'd0);
    assign o_res       = r_rq[r_rq_rd];
    assign do_pop      = i_res_pop && !o_res_empty;

    assign b        = {r_hi, i_tok.nibble};
    assign seg_over = ({r_seg, 16'h0000} >= IMAGE_LIMIT);
    assign wr_addr  = {1'b0, r_seg, 16'h0000} + 33'(r_addr) + 33'(r_cnt);
    assign wr_end   = wr_addr + 33'd1;

    always_comb begin
        n_phase = r_phase;
        n_low   = r_low;
        n_hi    = r_hi;
        n_len   = r_len;
        n_addr  = r_addr;
        n_cnt   = r_cnt;
        n_sum   = r_sum;
        n_seg   = r_seg;
        n_top   = r_top;
        n_err   = r_err;

        res             = '0;
        res.status      = ST_BUSY;
        res.error_code  = ERR_NONE;
        res.image_end   = r_top;

        if (r_err != ERR_NONE) begin
            res.status     = ST_ERROR;
            res.error_code = r_err;
        end else if (r_phase == PH_SKIP) begin
            if (i_tok.is_newline) begin
                n_phase = PH_COLON;
            end
        end else if (r_phase == PH_COLON) begin
            if (i_tok.is_colon) begin
                n_sum   = 8'd0;
                n_low   = 1'b0;
                n_cnt   = 8'd0;
                n_phase = PH_LEN;
            end else begin
                n_err          = ERR_COLON;
                res.status     = ST_ERROR;
                res.error_code = ERR_COLON;
            end
        end else if (!i_tok.is_hex) begin
            n_err          = ERR_HEX;
            res.status     = ST_ERROR;
            res.error_code = ERR_HEX;
        end else if (!r_low) begin
            // high nibble: hold it until the pair completes
            n_hi  = i_tok.nibble;
            n_low = 1'b1;
        end else begin
            n_low = 1'b0;
            n_sum = r_sum + b;
            unique case (r_phase)
                PH_LEN: begin
                    n_len   = b;
                    n_phase = PH_AHI;
                end
                PH_AHI: begin
                    n_addr  = {b, 8'h00};
                    n_phase = PH_ALO;
                end
                PH_ALO: begin
                    n_addr  = {r_addr[15:8], b};
                    n_phase = PH_TYPE;
                end
                PH_TYPE: begin
                    if (seg_over || b == REC_EOF || b == REC_START) begin
                        res.status = ST_ACCEPT;
                        n_phase    = PH_SKIP;
                    end else if (b == REC_DATA) begin
                        n_phase = (r_len != 8'd0) ? PH_DATA : PH_CHECK;
                    end else if (b == REC_ELA) begin
                        n_phase = PH_ELAHI;
                    end else begin
                        n_err          = ERR_TYPE;
                        res.status     = ST_ERROR;
                        res.error_code = ERR_TYPE;
                    end
                end
                PH_DATA: begin
                    if (wr_end > 33'(r_top)) begin
                        n_top = (wr_end > 33'(ADDR_MAX)) ? ADDR_MAX : wr_end[ADDR_W-1:0];
                    end
                    res.write_valid = 1'b1;
                    res.write_addr  = wr_addr[ADDR_W-1:0];
                    res.write_data  = b;
                    res.image_end   = n_top;
                    n_cnt = r_cnt + 8'd1;
                    if (n_cnt == r_len) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_ELAHI: begin
                    n_seg   = {b, 8'h00};
                    n_phase = PH_ELALO;
                end
                PH_ELALO: begin
                    n_seg   = {r_seg[15:8], b};
                    n_phase = PH_CHECK;
                end
                PH_CHECK: begin
                    n_sum = r_sum;
                    if (8'(r_sum + b) == 8'd0) begin
                        res.status = ST_ACCEPT;
                        n_phase    = PH_SKIP;
                    end else begin
                        n_err          = ERR_CHECKSUM;
                        res.status     = ST_ERROR;
                        res.error_code = ERR_CHECKSUM;
                    end
                end
                default: begin
                    n_phase = PH_SKIP;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_rq[r_rq_wr] <= res;
            r_hi          <= n_hi;
            r_len         <= n_len;
            r_addr        <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_COLON;
            r_low    <= 1'b0;
            r_cnt    <= 8'd0;
            r_sum    <= 8'd0;
            r_seg    <= 16'd0;
            r_top    <= '0;
            r_err    <= ERR_NONE;
            r_rq_wr  <= 1'b0;
            r_rq_rd  <= 1'b0;
            r_rq_cnt <= 2'd0;
        end else begin
            if (commit) begin
                r_phase <= n_phase;
                r_low   <= n_low;
                r_cnt   <= n_cnt;
                r_sum   <= n_sum;
                r_seg   <= n_seg;
                r_top   <= n_top;
                r_err   <= n_err;
                r_rq_wr <= ~r_rq_wr;
            end
            if (do_pop) begin
                r_rq_rd <= ~r_rq_rd;
            end
            r_rq_cnt <= r_rq_cnt + 2'(commit) - 2'(do_pop);
        end
    end

endmodule

>>> rtl/intel_hex_record_parser.sv
// ----------------------------------------------------------------------------
// intel_hex_record_parser: streaming hex record decoder
// Takes one file character per beat, returns one result beat per character.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  input     push / full        i_ch
//  result    pop / empty        o_write_valid, o_write_addr, o_write_data,
//                               o_status, o_error_code, o_image_end
//
//  One character per cycle sustained while results are popped. Rate is set by
//  the decode step of the record walker, one token per cycle. Each side has a
//  two-entry queue, token then result, so full and empty stall independently.
//  Synchronous active-low reset empties both queues and clears the decoder.
// ----------------------------------------------------------------------------
module intel_hex_record_parser import ihex_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        i_ch,
    output logic              empty,
    input  logic              pop,
    output logic              o_write_valid,
    output logic [ADDR_W-1:0] o_write_addr,
    output logic [7:0]        o_write_data,
    output logic [1:0]        o_status,
    output logic [2:0]        o_error_code,
    output logic [ADDR_W-1:0] o_image_end
);

    logic    tok_valid;
    t_token  tok;
    logic    tok_pop;
    t_result res;

    ihex_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_ch        (i_ch),
        .o_tok_valid (tok_valid),
        .o_tok       (tok),
        .i_tok_pop   (tok_pop)
    );

    ihex_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (tok_valid),
        .i_tok       (tok),
        .o_tok_pop   (tok_pop),
        .o_res_empty (empty),
        .o_res       (res),
        .i_res_pop   (pop)
    );

    assign o_write_valid = res.write_valid;
    assign o_write_addr  = res.write_addr;
    assign o_write_data  = res.write_data;
    assign o_status      = res.status;
    assign o_error_code  = res.error_code;
    assign o_image_end   = res.image_end;

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for intel_hex_record_parser
// Streams hex file text one character per beat, predicts each result beat with
// a behavioral copy of the record walker, and checks every beat field by field
// under several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module testbench;
    import ihex_pkg::*;

    localparam logic [7:0] REC_ESA = 8'h02;

    typedef enum logic [3:0] {
        WAIT_COLON, GET_LEN, GET_ADDR_HI, GET_ADDR_LO, GET_TYPE,
        GET_DATA, GET_SEG_HI, GET_SEG_LO, GET_CHECKSUM, SKIP_LINE
    } t_parse_phase;

    // Errors are sticky until reset, and reset happens once, so each run picks
    // a single way to end.
    typedef enum logic [1:0] {
        END_SKIP_COLON, END_SKIP_HEX, END_BAD_TYPE, END_BAD_CHECKSUM
    } t_run_ending;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              push    = 1'b0;
    logic              pop     = 1'b0;
    logic [7:0]        i_ch    = 8'h00;
    logic              full;
    logic              empty;
    logic              o_write_valid;
    logic [ADDR_W-1:0] o_write_addr;
    logic [7:0]        o_write_data;
    logic [1:0]        o_status;
    logic [2:0]        o_error_code;
    logic [ADDR_W-1:0] o_image_end;

    intel_hex_record_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_ch          (i_ch),
        .empty         (empty),
        .pop           (pop),
        .o_write_valid (o_write_valid),
        .o_write_addr  (o_write_addr),
        .o_write_data  (o_write_data),
        .o_status      (o_status),
        .o_error_code  (o_error_code),
        .o_image_end   (o_image_end)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // parser state as seen by the predictor
    t_parse_phase      parse_phase  = WAIT_COLON;
    logic              low_nibble   = 1'b0;
    logic [3:0]        high_nibble  = 4'h0;
    logic [7:0]        rec_len      = 8'h00;
    logic [15:0]       rec_addr     = 16'h0000;
    logic [7:0]        byte_count   = 8'h00;
    logic [7:0]        running_sum  = 8'h00;
    logic [15:0]       upper_seg    = 16'h0000;
    logic [ADDR_W-1:0] image_top    = '0;
    logic [2:0]        err_code     = ERR_NONE;

    t_result     results_due[$];
    t_result     oldest_result;
    logic [7:0]  payload_bytes[$];
    t_run_ending ending;

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_off_cycles = 0;
    int chars_sent      = 0;
    int records_sent    = 0;
    int results_checked = 0;
    int writes_checked  = 0;
    int mismatch_count  = 0;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
        if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
        if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
        return 5'd0;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] n, input logic lower);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return (lower ? 8'h57 : 8'h37) + 8'(n);
    endfunction

    // Advance the predicted parser by one character and return its result beat.
    function automatic t_result decode_char(input logic [7:0] c);
        t_result     r;
        logic [4:0]  hv;
        logic [7:0]  b;
        logic [31:0] seg_base;
        logic [31:0] wr_addr;
        logic [31:0] next_top;
        logic        accepted;
        r        = '0;
        r.image_end = image_top;
        seg_base = {upper_seg, 16'h0000};
        hv       = hex_value(c);
        accepted = 1'b0;
        if (err_code == ERR_NONE) begin
            if (parse_phase == SKIP_LINE) begin
                if (c == CH_NEWLINE) parse_phase = WAIT_COLON;
            end else if (parse_phase == WAIT_COLON) begin
                if (c == CH_COLON) begin
                    running_sum = 8'h00;
                    low_nibble  = 1'b0;
                    byte_count  = 8'h00;
                    parse_phase = GET_LEN;
                end else begin
                    err_code = ERR_COLON;
                end
            end else if (!hv[4]) begin
                err_code = ERR_HEX;
            end else if (!low_nibble) begin
                high_nibble = hv[3:0];
                low_nibble  = 1'b1;
            end else begin
                low_nibble = 1'b0;
                b = {high_nibble, hv[3:0]};
                case (parse_phase)
                    GET_LEN: begin
                        rec_len = b;
                        running_sum += b;
                        parse_phase = GET_ADDR_HI;
                    end
                    GET_ADDR_HI: begin
                        rec_addr[15:8] = b;
                        running_sum += b;
                        parse_phase = GET_ADDR_LO;
                    end
                    GET_ADDR_LO: begin
                        rec_addr[7:0] = b;
                        running_sum += b;
                        parse_phase = GET_TYPE;
                    end
                    GET_TYPE: begin
                        running_sum += b;
                        if (seg_base >= IMAGE_LIMIT) begin
                            accepted = 1'b1;
                        end else if (b == REC_DATA) begin
                            if (rec_len != 8'h00) parse_phase = GET_DATA;
                            else parse_phase = GET_CHECKSUM;
                        end else if (b == REC_EOF || b == REC_START) begin
                            accepted = 1'b1;
                        end else if (b == REC_ELA) begin
                            parse_phase = GET_SEG_HI;
                        end else begin
                            err_code = ERR_TYPE;
                        end
                    end
                    GET_DATA: begin
                        // the address is not wrapped at 16 bits: offsets carry into the segment
                        wr_addr  = seg_base + 32'(rec_addr) + 32'(byte_count);
                        next_top = wr_addr + 32'd1;
                        if (next_top > 32'(image_top)) begin
                            if (next_top > 32'(ADDR_MAX)) image_top = ADDR_MAX;
                            else image_top = next_top[ADDR_W-1:0];
                        end
                        r.write_valid = 1'b1;
                        r.write_addr  = wr_addr[ADDR_W-1:0];
                        r.write_data  = b;
                        r.image_end   = image_top;
                        running_sum += b;
                        byte_count  += 8'd1;
                        if (byte_count == rec_len) parse_phase = GET_CHECKSUM;
                    end
                    GET_SEG_HI: begin
                        upper_seg[15:8] = b;
                        running_sum += b;
                        parse_phase = GET_SEG_LO;
                    end
                    GET_SEG_LO: begin
                        upper_seg[7:0] = b;
                        running_sum += b;
                        parse_phase = GET_CHECKSUM;
                    end
                    GET_CHECKSUM: begin
                        if (8'(running_sum + b) == 8'h00) accepted = 1'b1;
                        else err_code = ERR_CHECKSUM;
                    end
                    default: parse_phase = SKIP_LINE;
                endcase
            end
        end
        if (accepted) begin
            r.status    = ST_ACCEPT;
            parse_phase = SKIP_LINE;
        end
        if (err_code != ERR_NONE) begin
            r.status     = ST_ERROR;
            r.error_code = err_code;
        end
        return r;
    endfunction

    // Offer one character; returns right after the posedge that took it.
    task automatic send_char(input logic [7:0] c);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push = 1'b1;
        i_ch = c;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        results_due.push_back(decode_char(c));
        chars_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_char(hex_digit(b[7:4], 1'($urandom_range(0, 1))));
        send_char(hex_digit(b[3:0], 1'($urandom_range(0, 1))));
    endtask

    task automatic fill_payload(input int n);
        repeat (n) payload_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    function automatic int random_junk_len();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // Send one line built from payload_bytes; sum_skew nonzero breaks the checksum.
    task automatic send_record(input logic [7:0] rtype, input logic [7:0] len_field,
                               input logic [15:0] rec_address, input logic [7:0] sum_skew,
                               input int junk_len);
        logic [7:0] sum;
        logic [7:0] junk;
        sum = len_field + rec_address[15:8] + rec_address[7:0] + rtype;
        foreach (payload_bytes[i]) sum += payload_bytes[i];
        send_char(CH_COLON);
        send_byte(len_field);
        send_byte(rec_address[15:8]);
        send_byte(rec_address[7:0]);
        send_byte(rtype);
        foreach (payload_bytes[i]) send_byte(payload_bytes[i]);
        send_byte(8'(8'h00 - sum + sum_skew));
        // trailing noise after the checksum is ignored up to the newline
        repeat (junk_len) begin
            do junk = 8'($urandom_range(0, 255)); while (junk == CH_NEWLINE);
            send_char(junk);
        end
        send_char(CH_NEWLINE);
        payload_bytes.delete();
        records_sent++;
    endtask

    // Lines that parse without error only; segment stays at 0 or 1 so nothing is skipped.
    task automatic send_random_record();
        int         pick;
        int         n;
        logic [7:0] len_field;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(0, 16);
            fill_payload(n);
            send_record(REC_DATA, 8'(n), 16'($urandom_range(0, 65535)), 8'd0,
                        random_junk_len());
        end else if (pick < 80) begin
            len_field = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'd2;
            payload_bytes.push_back(8'h00);
            payload_bytes.push_back(8'($urandom_range(0, 1)));
            send_record(REC_ELA, len_field, 16'($urandom_range(0, 65535)), 8'd0,
                        random_junk_len());
        end else if (pick < 90) begin
            n = $urandom_range(0, 2);
            fill_payload(n);
            send_record(REC_EOF, 8'(n), 16'h0000, 8'd0, random_junk_len());
        end else begin
            fill_payload(4);
            send_record(REC_START, 8'd4, 16'h0000, 8'd0, random_junk_len());
        end
    endtask

    // Lower push and wait until every predicted beat has been popped.
    task automatic drain_results();
        @(negedge i_clk);
        push = 1'b0;
        do @(posedge i_clk); while (results_due.size() != 0);
    endtask

    task automatic test_directed_records();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        payload_bytes.push_back(8'h00);
        send_record(REC_DATA, 8'd1, 16'h0000, 8'd0, 0);
        // offset past 0xFFFF carries into the next 64K
        payload_bytes.push_back(8'hFF);
        payload_bytes.push_back(8'h5A);
        send_record(REC_DATA, 8'd2, 16'hFFFF, 8'd0, 0);
        send_record(REC_DATA, 8'd0, 16'h1234, 8'd0, 0);
        send_record(REC_EOF, 8'd0, 16'h0000, 8'd0, 0);
        fill_payload(4);
        send_record(REC_START, 8'd4, 16'h0000, 8'd0, 0);
        // ELA always reads two payload bytes, whatever the length says
        payload_bytes.push_back(8'h00);
        payload_bytes.push_back(8'h01);
        send_record(REC_ELA, 8'd0, 16'h0000, 8'd0, 0);
        fill_payload(32);
        send_record(REC_DATA, 8'd32, 16'hFFF0, 8'd0, 0);
        payload_bytes.push_back(8'h00);
        payload_bytes.push_back(8'h00);
        send_record(REC_ELA, 8'hFF, 16'hFFFF, 8'd0, 0);
        fill_payload(16);
        send_record(REC_DATA, 8'd16, 16'h8000, 8'd0, 3);
        drain_results();
    endtask

    task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                       input int char_budget);
        int start;
        send_idle_pct  = sender_idle;
        recv_stall_pct = receiver_stall;
        start = chars_sent;
        while (chars_sent - start < char_budget) send_random_record();
        drain_results();
    endtask

    // Hold off the receiver long enough that both queues fill and full stalls
    // the sender, then let it all drain before going on.
    task automatic test_full_backpressure();
        int start;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 200;
        start = chars_sent;
        while (chars_sent - start < 120) send_random_record();
        drain_results();
    endtask

    // Move the segment to or past the image limit; every later record is
    // accepted at its type byte and dropped, whatever its type or checksum.
    task automatic test_segment_skip();
        logic [15:0] seg;
        logic [7:0]  rtype;
        send_idle_pct  = 21;
        recv_stall_pct = 21;
        seg = $urandom_range(0, 1) ? 16'hFFFF : 16'h0002;
        payload_bytes.push_back(seg[15:8]);
        payload_bytes.push_back(seg[7:0]);
        send_record(REC_ELA, 8'd2, 16'h0000, 8'd0, 0);
        for (int i = 0; i < 12; i++) begin
            case (i % 4)
                0:       rtype = REC_DATA;
                1:       rtype = REC_ESA;
                2:       rtype = REC_ELA;
                default: rtype = 8'($urandom_range(0, 255));
            endcase
            fill_payload($urandom_range(0, 6));
            send_record(rtype, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                        8'($urandom_range(0, 255)), random_junk_len());
        end
        drain_results();
    endtask

    task automatic test_sticky_error();
        logic [7:0] c;
        logic [4:0] hv;
        int         n;
        send_idle_pct  = 21;
        recv_stall_pct = 21;
        case (ending)
            END_SKIP_COLON: begin
                if ($urandom_range(0, 1)) begin
                    send_char(CH_NEWLINE);
                end else begin
                    do c = 8'($urandom_range(0, 255)); while (c == CH_COLON);
                    send_char(c);
                end
            end
            END_SKIP_HEX: begin
                // stay short of the type byte, or the skipped line would swallow the fault
                send_char(CH_COLON);
                repeat ($urandom_range(0, 7))
                    send_char(hex_digit(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
                if ($urandom_range(0, 1)) begin
                    send_char(CH_NEWLINE);
                end else begin
                    do begin
                        c  = 8'($urandom_range(0, 255));
                        hv = hex_value(c);
                    end while (hv[4]);
                    send_char(c);
                end
            end
            END_BAD_TYPE: begin
                fill_payload(2);
                send_record($urandom_range(0, 1) ? REC_ESA : 8'($urandom_range(5, 255)),
                            8'd2, 16'h0100, 8'd0, 0);
            end
            default: begin
                n = $urandom_range(0, 8);
                fill_payload(n);
                send_record(REC_DATA, 8'(n), 16'($urandom_range(0, 65535)),
                            8'($urandom_range(1, 255)), 0);
            end
        endcase
        // the error must hold through anything that follows
        repeat (30) send_char(8'($urandom_range(0, 255)));
        fill_payload(2);
        send_record(REC_DATA, 8'd2, 16'h0010, 8'd0, 0);
        drain_results();
    endtask

    // receiver side: a hold-off count wins over random stalls
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            pop = 1'b0;
            hold_off_cycles = hold_off_cycles - 1;
        end else begin
            pop = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 100)
                $display("%0t: %s differs, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (results_due.size() == 0) begin
                mismatch_count++;
                $display("%0t: result beat with nothing pending, expected none, actual status %0d",
                         $time, o_status);
            end else begin
                oldest_result = results_due.pop_front();
                compare_field("write_valid", 32'(oldest_result.write_valid),
                              32'(o_write_valid));
                compare_field("write_addr", 32'(oldest_result.write_addr),
                              32'(o_write_addr));
                compare_field("write_data", 32'(oldest_result.write_data),
                              32'(o_write_data));
                compare_field("status", 32'(oldest_result.status), 32'(o_status));
                compare_field("error_code", 32'(oldest_result.error_code),
                              32'(o_error_code));
                compare_field("image_end", 32'(oldest_result.image_end),
                              32'(o_image_end));
                results_checked++;
                if (oldest_result.write_valid) writes_checked++;
            end
        end
    end

    initial begin
        ending = t_run_ending'($urandom_range(0, 3));
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_records();
        test_random_traffic(0, 0, 75);
        test_random_traffic(87, 0, 75);
        test_random_traffic(0, 87, 75);
        test_random_traffic(21, 21, 75);
        test_full_backpressure();
        if (ending == END_SKIP_COLON || ending == END_SKIP_HEX) test_segment_skip();
        test_sticky_error();
        repeat (10) @(posedge i_clk);
        $display("Streamed %0d characters in %0d lines; %0d beats checked, %0d were writes.",
                 chars_sent, records_sent, results_checked, writes_checked);
        $display("Image end reached 0x%0h; run closed on %s.", image_top, ending.name());
        if (mismatch_count == 0 && results_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timed out with %0d beats outstanding", results_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> intel_hex_record_parser.f
rtl/ihex_pkg.sv
rtl/ihex_front.sv
rtl/ihex_back.sv
rtl/intel_hex_record_parser.sv
sim/testbench.sv
